[hdl/hts_pkg.sv]
// ----------------------------------------------------------------------------
// hts_pkg
// Shared constants, state type and arctangent table for the heading tracker.
// ----------------------------------------------------------------------------
package hts_pkg;

    // configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_RATE = 2'd2;

    // field widths
    localparam int CENTER_W = 12;
    localparam int RATE_W   = 16;
    localparam int TICKS_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int ZACC_W   = 32;

    localparam logic [CENTER_W-1:0] CENTER_X_RST  = 12'd400;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 12'd300;
    localparam logic [RATE_W-1:0]   TURN_RATE_RST = 16'd839;

    // binary angle constants
    localparam logic [ANGLE_W-1:0] HALF_TURN   = 16'h8000;
    localparam logic [ZACC_W-1:0]  Z_HALF_TURN = 32'h8000_0000;
    localparam logic [ZACC_W-1:0]  Z_ROUND     = 32'h0000_8000;

    localparam int OFFSET_FRAC  = 14;
    localparam int RATE_FRAC    = 8;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROTATE,
        BK_SLEW
    } bk_state_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [ZACC_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZACC_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hdl/hts_if.sv]
// ----------------------------------------------------------------------------
// hts_if
// Valid/ready channels of the heading tracker: target requests and results.
// ----------------------------------------------------------------------------
interface hts_req_if
    import hts_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
    logic [TICKS_W-1:0]    elapsed_ticks;

    modport source (output valid, output target_x, output target_y,
                    output elapsed_ticks, input ready);
    modport sink   (input valid, input target_x, input target_y,
                    input elapsed_ticks, output ready);
endinterface

interface hts_rsp_if
    import hts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] heading;
    logic [ANGLE_W-1:0] target_angle;
    logic               on_target;

    modport source (output valid, output heading, output target_angle,
                    output on_target, input ready);
    modport sink   (input valid, input heading, input target_angle,
                    input on_target, output ready);
endinterface

[hdl/hts_front.sv]
// ----------------------------------------------------------------------------
// hts_front
// Config registers, target offset and half-plane fold, turn limit product.
// ----------------------------------------------------------------------------
module hts_front
    import hts_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hts_req_if.sink                req,
    output logic                   push,
    output logic [2*(COORD_BITS+1)+ANGLE_W+1:0] push_data,
    input  logic                   full
);

    localparam int DW       = COORD_BITS + 1;
    localparam int WIDE_W   = COORD_BITS + CENTER_W;
    localparam int PROD_W   = RATE_W + TICKS_W;
    localparam int SCALED_W = PROD_W - RATE_FRAC;

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [RATE_W-1:0]   turn_rate_reg;

    logic [WIDE_W-1:0]     cx_wide;
    logic [WIDE_W-1:0]     cy_wide;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic signed [DW-1:0]  dx_raw;
    logic signed [DW-1:0]  dy_raw;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic                  half;
    logic                  zero;
    logic [PROD_W-1:0]     prod;
    logic [SCALED_W-1:0]   scaled;
    logic [ANGLE_W-1:0]    limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            turn_rate_reg <= TURN_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_data[CENTER_W-1:0];
                REG_TURN_RATE: turn_rate_reg <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // center taken modulo the coordinate range
    assign cx_wide = WIDE_W'(center_x_reg);
    assign cy_wide = WIDE_W'(center_y_reg);
    assign cx      = cx_wide[COORD_BITS-1:0];
    assign cy      = cy_wide[COORD_BITS-1:0];

    assign dx_raw = $signed({1'b0, req.target_x}) - $signed({1'b0, cx});
    assign dy_raw = $signed({1'b0, req.target_y}) - $signed({1'b0, cy});

    // fold the left half plane onto the right one, a half turn preloaded
    assign half = dx_raw[DW-1];
    assign zero = (dx_raw == '0) && (dy_raw == '0);
    assign dx   = half ? -dx_raw : dx_raw;
    assign dy   = half ? -dy_raw : dy_raw;

    assign prod   = PROD_W'(turn_rate_reg) * PROD_W'(req.elapsed_ticks);
    assign scaled = prod[PROD_W-1:RATE_FRAC];
    assign limit  = (scaled > SCALED_W'(HALF_TURN)) ? HALF_TURN : scaled[ANGLE_W-1:0];

    assign req.ready = !full;
    assign push      = req.valid && !full;
    assign push_data = {half, zero, limit, dx, dy};

endmodule

[hdl/hts_queue.sv]
// ----------------------------------------------------------------------------
// hts_queue
// Small first-in first-out buffer between the front and the CORDIC back end.
// ----------------------------------------------------------------------------
module hts_queue
    import hts_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/hts_back.sv]
// ----------------------------------------------------------------------------
// hts_back
// Iterative CORDIC vectoring (one step a cycle), slew limit and result beat.
// ----------------------------------------------------------------------------
module hts_back
    import hts_pkg::*;
#(
    parameter int COORD_BITS   = 12,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   pop,
    input  logic [2*(COORD_BITS+1)+ANGLE_W+1:0] pop_data,
    input  logic                   empty,
    hts_rsp_if.source              rsp
);

    localparam int NSTEP  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int DW     = COORD_BITS + 1;
    // scaled offset times cordic gain and sqrt(2) stays below 2^(COORD_BITS+16)
    localparam int XW     = COORD_BITS + OFFSET_FRAC + 3;

    logic                 cmd_half;
    logic                 cmd_zero;
    logic [ANGLE_W-1:0]   cmd_limit;
    logic signed [DW-1:0] cmd_dx;
    logic signed [DW-1:0] cmd_dy;

    bk_state_t            state_reg;
    bk_state_t            state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_reg;
    logic signed [XW-1:0] y_next;
    logic [ZACC_W-1:0]    z_reg;
    logic [ZACC_W-1:0]    z_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic [ANGLE_W-1:0]   limit_reg;
    logic [ANGLE_W-1:0]   limit_next;
    logic [ANGLE_W-1:0]   heading_reg;
    logic [ANGLE_W-1:0]   heading_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ANGLE_W-1:0]   out_heading_reg;
    logic [ANGLE_W-1:0]   out_heading_next;
    logic [ANGLE_W-1:0]   out_target_reg;
    logic [ANGLE_W-1:0]   out_target_next;
    logic                 out_on_target_reg;
    logic                 out_on_target_next;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic [ZACC_W-1:0]    atan_val;
    logic [ZACC_W-1:0]    z_round;
    logic [ANGLE_W-1:0]   target;
    logic [ANGLE_W-1:0]   diff;
    logic [ANGLE_W-1:0]   back_diff;
    logic [ANGLE_W-1:0]   fwd_step;
    logic [ANGLE_W-1:0]   back_step;
    logic [ANGLE_W-1:0]   new_heading;
    logic                 load;

    assign {cmd_half, cmd_zero, cmd_limit, cmd_dx, cmd_dy} = pop_data;

    // arithmetic shift rounds toward minus infinity
    assign xs       = x_reg >>> step_reg;
    assign ys       = y_reg >>> step_reg;
    assign atan_val = atan_lut(ATAN_IDX_W'(step_reg));

    assign z_round = z_reg + Z_ROUND;
    assign target  = zero_reg ? '0 : z_round[ZACC_W-1:ZACC_W-ANGLE_W];

    // shorter way round, exact half turn goes positive
    assign diff        = target - heading_reg;
    assign back_diff   = '0 - diff;
    assign fwd_step    = (diff < limit_reg) ? diff : limit_reg;
    assign back_step   = (back_diff < limit_reg) ? back_diff : limit_reg;
    assign new_heading = (diff <= HALF_TURN) ? heading_reg + fwd_step
                                             : heading_reg - back_step;

    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        z_next             = z_reg;
        zero_next          = zero_reg;
        limit_next         = limit_reg;
        heading_next       = heading_reg;
        out_valid_next     = out_valid_reg;
        out_heading_next   = out_heading_reg;
        out_target_next    = out_target_reg;
        out_on_target_next = out_on_target_reg;
        pop                = 1'b0;
        load               = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    x_next     = XW'(cmd_dx) <<< OFFSET_FRAC;
                    y_next     = XW'(cmd_dy) <<< OFFSET_FRAC;
                    z_next     = cmd_half ? Z_HALF_TURN : '0;
                    zero_next  = cmd_zero;
                    limit_next = cmd_limit;
                    step_next  = '0;
                    state_next = BK_ROTATE;
                end
            end
            BK_ROTATE:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_val;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_val;
                end
                if (step_reg == STEP_W'(NSTEP - 1))
                begin
                    state_next = BK_SLEW;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            BK_SLEW:
            begin
                // output register free or emptied this cycle
                if (!out_valid_reg || rsp.ready)
                begin
                    load               = 1'b1;
                    heading_next       = new_heading;
                    out_valid_next     = 1'b1;
                    out_heading_next   = new_heading;
                    out_target_next    = target;
                    out_on_target_next = (new_heading == target);
                    state_next         = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            heading_reg   <= heading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg             <= x_next;
        y_reg             <= y_next;
        z_reg             <= z_next;
        zero_reg          <= zero_next;
        limit_reg         <= limit_next;
        out_heading_reg   <= out_heading_next;
        out_target_reg    <= out_target_next;
        out_on_target_reg <= out_on_target_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.heading      = out_heading_reg;
    assign rsp.target_angle = out_target_reg;
    assign rsp.on_target    = out_on_target_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ROTATE) |-> (step_reg <= STEP_W'(NSTEP - 1)))
        else $error("cordic step counter past last iteration");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_SLEW) |=> $stable(heading_reg))
        else $error("heading moved outside slew step");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (rsp.valid && (rsp.heading == heading_reg)))
        else $error("result beat missing after slew");

endmodule

[hdl/heading_tracker_slew_limited_top.sv]
// ----------------------------------------------------------------------------
// heading_tracker_slew_limited_top
// Each request beat gives a target point and elapsed ticks; the block finds
// the target direction by CORDIC atan2 about the configured center and turns
// its stored heading toward it, the shorter way, by at most turn_rate times
// elapsed_ticks (8 fractional bits dropped, capped at a half turn). Angles are
// 65536 units per turn. One result beat per request. For each item the back
// end takes it from the queue, runs the CORDIC iterations one per cycle in
// the single shift-add unit, and then does the slew update into the output
// register, waiting while that register still holds an unaccepted result. The
// front takes a request in the cycle it arrives unless the queue is full, and
// buffers up to two more while the back end works; the back end takes no new
// item until it is through with the last one.
// ----------------------------------------------------------------------------
module heading_tracker_slew_limited_top
    import hts_pkg::*;
#(
    parameter int COORD_BITS   = 12,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    hts_req_if.sink                req,
    hts_rsp_if.source              rsp
);

    localparam int CMD_W       = 2 * (COORD_BITS + 1) + ANGLE_W + 2;
    localparam int QUEUE_DEPTH = 2;

    logic             push;
    logic [CMD_W-1:0] push_data;
    logic             full;
    logic             pop;
    logic [CMD_W-1:0] pop_data;
    logic             empty;

    hts_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    hts_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    hts_back #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .rsp      (rsp)
    );

endmodule

[sim/heading_tracker_slew_limited_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_tracker_slew_limited_top_test
// Drives target points through the heading tracker under several center and
// turn-rate settings, with random gaps and stalls on both channels. A local
// CORDIC atan2 and slew model predicts each result beat; results are checked
// field by field in order.
// ----------------------------------------------------------------------------
module heading_tracker_slew_limited_top_test;
    import hts_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 112;
    localparam int DRAIN_CYCLES = CORDIC_STEPS + 12;

    typedef struct packed {
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
        logic [TICKS_W-1:0]    ticks;
    } target_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] heading;
        logic [ANGLE_W-1:0] target_angle;
        logic               on_target;
    } heading_result_t;

    class heading_scoreboard;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [RATE_W-1:0]   turn_rate;
        logic [ANGLE_W-1:0]  heading;
        heading_result_t     pending_headings[$];
        int                  mismatches;
        logic [ZACC_W-1:0]   arctan_steps[ATAN_ENTRIES];

        function new();
            center_x   = CENTER_X_RST;
            center_y   = CENTER_Y_RST;
            turn_rate  = TURN_RATE_RST;
            heading    = '0;
            mismatches = 0;
            arctan_steps = '{
                32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
                32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
                32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
                32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
                32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
                32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] value);
            if (idx == REG_CENTER_X)
                center_x = value[CENTER_W-1:0];
            else if (idx == REG_CENTER_Y)
                center_y = value[CENTER_W-1:0];
            else if (idx == REG_TURN_RATE)
                turn_rate = value[RATE_W-1:0];
        endfunction

        function logic [ANGLE_W-1:0] cordic_direction(longint dx, longint dy);
            longint            x;
            longint            y;
            longint            xs;
            longint            ys;
            logic [ZACC_W-1:0] z;
            logic [ZACC_W-1:0] rounded;
            if (dx == 0 && dy == 0)
                return '0;
            x = dx <<< OFFSET_FRAC;
            y = dy <<< OFFSET_FRAC;
            z = '0;
            // left half plane: pre-rotate by a half turn
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = Z_HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_steps[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_steps[i];
                end
            end
            rounded = z + Z_ROUND;
            return rounded[ZACC_W-1:ZACC_W-ANGLE_W];
        endfunction

        function void note_target(target_item_t item);
            longint             dx;
            longint             dy;
            logic [ANGLE_W-1:0] target;
            logic [31:0]        limit;
            logic [31:0]        diff;
            logic [31:0]        back;
            logic [31:0]        turn;
            heading_result_t    res;
            dx     = longint'(item.target_x) - longint'(center_x);
            dy     = longint'(item.target_y) - longint'(center_y);
            target = cordic_direction(dx, dy);
            limit  = ({16'b0, turn_rate} * {16'b0, item.ticks}) >> RATE_FRAC;
            if (limit > 32'(HALF_TURN))
                limit = 32'(HALF_TURN);
            diff = 32'(ANGLE_W'(target - heading));
            if (diff != 0)
            begin
                // exact half turn goes the positive way
                if (diff <= 32'(HALF_TURN))
                begin
                    turn    = (diff < limit) ? diff : limit;
                    heading = heading + turn[ANGLE_W-1:0];
                end
                else
                begin
                    back    = 32'd65536 - diff;
                    turn    = (back < limit) ? back : limit;
                    heading = heading - turn[ANGLE_W-1:0];
                end
            end
            res.heading      = heading;
            res.target_angle = target;
            res.on_target    = (heading == target);
            pending_headings.push_back(res);
        endfunction

        function void check_result(heading_result_t actual);
            heading_result_t want;
            if (pending_headings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: heading %0d angle %0d on_target %0b",
                             actual.heading, actual.target_angle, actual.on_target);
                return;
            end
            want = pending_headings.pop_front();
            if (want != actual)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %0d %0b got %0d %0d %0b",
                             want.heading, want.target_angle, want.on_target,
                             actual.heading, actual.target_angle, actual.on_target);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     cycles;
    bit                     burst_mode;
    target_item_t           last_item;
    heading_scoreboard      tracker_sb;

    hts_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
    hts_rsp_if                            rsp_if ();

    heading_tracker_slew_limited_top #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if.sink),
        .rsp       (rsp_if.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("heading_tracker_slew_limited_top_test failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return burst_mode ? 0 : int'($urandom_range(0, 4));
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        tracker_sb.write_register(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_tracker(input int cx, input int cy, input int rate);
        write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(REG_TURN_RATE, CFG_DATA_W'(rate));
    endtask

    task automatic send_target(input int tx, input int ty, input int ticks);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.target_x      = COORD_BITS'(tx);
        req_if.target_y      = COORD_BITS'(ty);
        req_if.elapsed_ticks = TICKS_W'(ticks);
        req_if.valid         = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        last_item.target_x = COORD_BITS'(tx);
        last_item.target_y = COORD_BITS'(ty);
        last_item.ticks    = TICKS_W'(ticks);
        tracker_sb.note_target(last_item);
    endtask

    // drop valid and let every outstanding result come back
    task automatic settle();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (tracker_sb.pending_headings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        send_target(400, 300, 100);       // zero offset
        send_target(4095, 300, 0);        // no elapsed time
        send_target(0, 300, 65535);       // half turn away, saturated limit
        send_target(4095, 4095, 1);
        send_target(0, 0, 65535);
        send_target(400, 4095, 30);
        send_target(400, 0, 200);
        send_target(0, 4095, 65535);
        send_target(4095, 0, 65535);
        send_target(2000, 300, 65535);    // settle on the +x axis
        send_target(0, 300, 40);          // half turn with a small limit
        settle();
        write_reg(REG_TURN_RATE, '0);
        send_target(4095, 4095, 65535);   // zero rate holds the heading
        settle();
        write_reg(REG_TURN_RATE, 16'hFFFF);
        send_target(0, 0, 1);
        send_target(4095, 4095, 65535);
        settle();
        set_tracker(0, 0, 839);
        send_target(0, 0, 500);
        send_target(4095, 4095, 3);
        send_target(0, 4095, 65535);
        send_target(4095, 0, 7);
        settle();
        set_tracker(4095, 4095, 839);
        send_target(4095, 4095, 9);
        send_target(0, 0, 65535);
        send_target(4095, 0, 2);
        send_target(0, 4095, 65535);
        settle();
    endtask

    task automatic send_random_target();
        int tx;
        int ty;
        int ticks;
        int pick;
        pick = $urandom_range(0, 9);
        tx   = $urandom_range(0, 4095);
        ty   = $urandom_range(0, 4095);
        case (pick) inside
            0:
            begin
                tx = tracker_sb.center_x;
                ty = tracker_sb.center_y;
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    tx = tracker_sb.center_x;
                else
                    ty = tracker_sb.center_y;
            end
            2:
            begin
                tx = $urandom_range(0, 1) ? 4095 : 0;
                ty = $urandom_range(0, 1) ? 4095 : 0;
            end
            [3:5]:
            begin
                // chase the same target so the heading converges
                tx = last_item.target_x;
                ty = last_item.target_y;
            end
            default: ;
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
            ticks = 0;
        else if (pick == 1)
            ticks = 65535;
        else if (pick <= 3)
            ticks = $urandom_range(0, 65535);
        else
            ticks = $urandom_range(1, 255);
        send_target(tx, ty, ticks);
    endtask

    initial
    begin
        int cx;
        int cy;
        int rate;
        heading_result_t got;
        tracker_sb           = new();
        cycles               = 0;
        burst_mode           = 1'b0;
        last_item            = '0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.target_x      = '0;
        req_if.target_y      = '0;
        req_if.elapsed_ticks = '0;
        rsp_if.ready         = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        fork
            forever
            begin
                int stall;
                stall = draw_wait();
                @(negedge clk);
                if (stall > 0)
                begin
                    rsp_if.ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
                rsp_if.ready = 1'b1;
                do @(posedge clk); while (!rsp_if.valid);
                got.heading      = rsp_if.heading;
                got.target_angle = rsp_if.target_angle;
                got.on_target    = rsp_if.on_target;
                tracker_sb.check_result(got);
            end
        join_none

        run_directed();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    cx   = 400;
                    cy   = 300;
                    rate = 839;
                end
                1:
                begin
                    cx   = 0;
                    cy   = 0;
                    rate = 65535;
                end
                2:
                begin
                    cx   = 4095;
                    cy   = 4095;
                    rate = 0;
                end
                3:
                begin
                    cx   = 2048;
                    cy   = 2048;
                    rate = 1;
                end
                4:
                begin
                    cx   = 0;
                    cy   = 4095;
                    rate = 256;
                end
                5:
                begin
                    cx   = 4095;
                    cy   = 0;
                    rate = 12000;
                end
                default:
                begin
                    cx   = $urandom_range(0, 4095);
                    cy   = $urandom_range(0, 4095);
                    rate = $urandom_range(0, 65535);
                end
            endcase
            set_tracker(cx, cy, rate);
            burst_mode = (phase % 3 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_target();
            settle();
            burst_mode = 1'b0;
        end

        if (tracker_sb.mismatches == 0 && tracker_sb.pending_headings.size() == 0)
            $display("heading_tracker_slew_limited_top_test passed");
        else
            $display("heading_tracker_slew_limited_top_test failed");
        $finish;
    end

endmodule

[sim.f]
hdl/hts_pkg.sv
hdl/hts_if.sv
hdl/hts_front.sv
hdl/hts_queue.sv
hdl/hts_back.sv
hdl/heading_tracker_slew_limited_top.sv
sim/heading_tracker_slew_limited_top_test.sv
